[hw/rtl/tlm_pkg.sv]
// Package for the text line metrics block: word types, register indexes,
// character codes and width constants. No dependencies.
package tlm_pkg;

  localparam int TABLE_DEPTH     = 256;
  localparam int CODE_BITS       = 8;
  localparam int TABLE_ADDR_BITS = $clog2(TABLE_DEPTH);
  localparam int ADV_BITS        = 8;
  localparam int ENTRY_BITS      = ADV_BITS + 1;
  localparam int SPAN_BITS       = 9;
  localparam int METRIC_BITS     = 16;
  localparam int WIDTH_BITS      = 24;
  localparam int DESCENT_BITS    = 32;
  localparam int COUNT_BITS      = 16;
  localparam int SKIP_BITS       = 4;

  localparam logic [CODE_BITS-1:0] ESC_CODE = 8'd27;
  localparam logic [CODE_BITS-1:0] CR_CODE  = 8'd13;
  localparam logic [CODE_BITS-1:0] LF_CODE  = 8'd10;
  localparam logic [CODE_BITS-1:0] CHAR_M   = 8'h4D;
  localparam logic [CODE_BITS-1:0] CHAR_T   = 8'h54;
  localparam logic [CODE_BITS-1:0] CHAR_L   = 8'h4C;
  localparam logic [CODE_BITS-1:0] CHAR_F   = 8'h46;
  localparam logic [CODE_BITS-1:0] UPPER_A  = 8'h41;
  localparam logic [CODE_BITS-1:0] UPPER_Z  = 8'h5A;
  localparam logic [CODE_BITS-1:0] LOWER_A  = 8'h61;
  localparam logic [CODE_BITS-1:0] LOWER_Z  = 8'h7A;
  localparam logic [CODE_BITS-1:0] CASE_BIT = 8'h20;

  localparam logic [SKIP_BITS-1:0] SKIP_M  = 4'd3;
  localparam logic [SKIP_BITS-1:0] SKIP_TL = 4'd6;
  localparam logic [SKIP_BITS-1:0] SKIP_F  = 4'd12;

  localparam logic action_load    = 1'b0;
  localparam logic action_measure = 1'b1;

  typedef enum logic [1:0] {
    CFG_FIRST_CODE   = 2'd0,
    CFG_CODE_SPAN    = 2'd1,
    CFG_FONT_ASCENT  = 2'd2,
    CFG_FONT_DESCENT = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic                       action;
    logic [CODE_BITS-1:0]       code;
    logic                       entry_present;
    logic signed [ADV_BITS-1:0] entry_advance;
    logic                       last_char;
  } in_word_t;

  typedef struct packed {
    logic signed [WIDTH_BITS-1:0]   text_width;
    logic signed [METRIC_BITS-1:0]  text_ascent;
    logic signed [DESCENT_BITS-1:0] text_descent;
  } out_word_t;

endpackage

[hw/rtl/tlm_ram.sv]
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module tlm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

[hw/rtl/text_line_metrics.sv]
// Text line metrics top level: glyph table, per-line accumulators, result register.
// Depends on tlm_pkg and tlm_ram.
//
//  port group | role   | word       | notes
//  in_*       | input  | in_word_t  | load table entry or measure one character
//  out_*      | output | out_word_t | one word per measured character marked last
//  cfg_*      | input  | index+data | four registers, always ready
//
// One item per cycle while the result register is not stalled; the result word passes
// through the character stage (with table read data), then the result register.
// The glyph table is read at the code and at its other-case letter in the same
// cycle through two read ports; loads write it at the accept edge.
// Reset clears the table through per-entry valid bits; no sweep.
// A stalled result register holds the character stage, which in turn holds input.
module text_line_metrics
  import tlm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_word_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_word_t              out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  cfg_index_t             cfg_index,
  input  logic [METRIC_BITS-1:0] cfg_data
);

  // configuration registers
  logic [CODE_BITS-1:0]          first_code;
  logic [SPAN_BITS-1:0]          code_span;
  logic signed [METRIC_BITS-1:0] font_ascent;
  logic signed [METRIC_BITS-1:0] font_descent;

  // string state
  logic signed [WIDTH_BITS-1:0] line_width, line_width_next;
  logic signed [WIDTH_BITS-1:0] widest_width, widest_width_next;
  logic [COUNT_BITS-1:0]        line_count, line_count_next;
  logic                         esc_pending, esc_pending_next;
  logic [SKIP_BITS-1:0]         skip_left, skip_left_next;

  // character stage
  logic                 s1_valid;
  logic [CODE_BITS-1:0] s1_code;
  logic                 s1_last;
  logic                 s1_cov_a, s1_cov_b, s1_letter;
  logic                 s1_vld_a, s1_vld_b;
  logic [ENTRY_BITS-1:0] rd_a, rd_b;

  logic [TABLE_DEPTH-1:0] entry_valid;

  logic in_fire, out_free, s1_fire;
  logic load_fire, is_letter, cov_a, cov_b;
  logic [CODE_BITS-1:0]       alt_code;
  logic [TABLE_ADDR_BITS-1:0] idx_a, idx_b;
  logic [CODE_BITS+1:0]       range_end;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign s1_fire   = s1_valid && out_free;
  assign in_ready  = !s1_valid || out_free;
  assign in_fire   = in_valid && in_ready;
  assign load_fire = in_fire && (in_data.action == action_load);

  always_ff @(posedge clk) begin
    if (rst) begin
      first_code   <= '0;
      code_span    <= SPAN_BITS'(TABLE_DEPTH);
      font_ascent  <= '0;
      font_descent <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FIRST_CODE:   first_code   <= cfg_data[CODE_BITS-1:0];
        CFG_CODE_SPAN:    code_span    <= cfg_data[SPAN_BITS-1:0];
        CFG_FONT_ASCENT:  font_ascent  <= cfg_data;
        CFG_FONT_DESCENT: font_descent <= cfg_data;
        default: ;
      endcase
    end
  end

  // address and range checks for the code and its other-case letter
  always_comb begin
    is_letter = ((in_data.code >= UPPER_A) && (in_data.code <= UPPER_Z)) ||
                ((in_data.code >= LOWER_A) && (in_data.code <= LOWER_Z));
    alt_code  = in_data.code ^ CASE_BIT;
    range_end = {2'b0, first_code} + {1'b0, code_span};
    cov_a     = (in_data.code >= first_code) && ({2'b0, in_data.code} < range_end);
    cov_b     = (alt_code >= first_code) && ({2'b0, alt_code} < range_end);
    idx_a     = TABLE_ADDR_BITS'(in_data.code - first_code);
    idx_b     = TABLE_ADDR_BITS'(alt_code - first_code);
  end

  tlm_ram #(
    .WIDTH(ENTRY_BITS),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk    (clk),
    .we     (load_fire),
    .waddr  (TABLE_ADDR_BITS'(in_data.code)),
    .wdata  ({in_data.entry_present, in_data.entry_advance}),
    .re     (in_fire),
    .raddr_a(idx_a),
    .raddr_b(idx_b),
    .rdata_a(rd_a),
    .rdata_b(rd_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (load_fire) begin
      entry_valid[TABLE_ADDR_BITS'(in_data.code)] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= (in_data.action == action_measure);
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_code   <= in_data.code;
      s1_last   <= in_data.last_char;
      s1_cov_a  <= cov_a;
      s1_cov_b  <= cov_b;
      s1_letter <= is_letter;
      s1_vld_a  <= entry_valid[idx_a];
      s1_vld_b  <= entry_valid[idx_b];
    end
  end

  // glyph lookup with case fallback
  logic                       hit_a, hit_b, hit;
  logic signed [ADV_BITS-1:0] adv;
  logic signed [WIDTH_BITS:0] sum;
  logic signed [WIDTH_BITS-1:0] sum_sat;

  always_comb begin
    hit_a   = s1_vld_a && rd_a[ADV_BITS];
    hit_b   = s1_letter && s1_cov_b && s1_vld_b && rd_b[ADV_BITS];
    hit     = s1_cov_a && (hit_a || hit_b);
    adv     = hit_a ? rd_a[ADV_BITS-1:0] : rd_b[ADV_BITS-1:0];
    sum     = {line_width[WIDTH_BITS-1], line_width} +
              {{(WIDTH_BITS-ADV_BITS+1){adv[ADV_BITS-1]}}, adv};
    // clamp on overflow
    if (sum[WIDTH_BITS] != sum[WIDTH_BITS-1]) begin
      sum_sat = sum[WIDTH_BITS] ? {1'b1, {(WIDTH_BITS-1){1'b0}}}
                                : {1'b0, {(WIDTH_BITS-1){1'b1}}};
    end else begin
      sum_sat = sum[WIDTH_BITS-1:0];
    end
  end

  always_comb begin
    line_width_next   = line_width;
    widest_width_next = widest_width;
    line_count_next   = line_count;
    esc_pending_next  = esc_pending;
    skip_left_next    = skip_left;
    if (skip_left != '0) begin
      skip_left_next = skip_left - 1'b1;
    end else if (esc_pending && (s1_code == CHAR_M || s1_code == CHAR_T ||
                                 s1_code == CHAR_L || s1_code == CHAR_F)) begin
      esc_pending_next = 1'b0;
      case (s1_code) inside
        CHAR_M:         skip_left_next = SKIP_M;
        CHAR_T, CHAR_L: skip_left_next = SKIP_TL;
        default:        skip_left_next = SKIP_F;
      endcase
    end else begin
      esc_pending_next = 1'b0;
      if (s1_code == ESC_CODE) begin
        esc_pending_next = 1'b1;
      end else if (s1_code == CR_CODE) begin
        // ignore
      end else if (s1_code == LF_CODE) begin
        if (!s1_last) begin
          if (line_width > widest_width) begin
            widest_width_next = line_width;
          end
          line_width_next = '0;
          if (line_count != '1) begin
            line_count_next = line_count + 1'b1;
          end
        end
      end else if (hit) begin
        line_width_next = sum_sat;
      end
    end
  end

  // total descent: lines * (ascent + descent) - ascent, clamped to 32 bits
  logic signed [METRIC_BITS:0]   font_sum;
  logic signed [2*METRIC_BITS+1:0] prod;
  logic signed [2*METRIC_BITS+2:0] desc_full;
  logic signed [DESCENT_BITS-1:0]  desc_sat;
  logic signed [WIDTH_BITS-1:0]    width_out;

  always_comb begin
    font_sum  = {font_ascent[METRIC_BITS-1], font_ascent} +
                {font_descent[METRIC_BITS-1], font_descent};
    prod      = $signed({{(METRIC_BITS+2){1'b0}}, line_count}) *
                $signed({{(METRIC_BITS+1){font_sum[METRIC_BITS]}}, font_sum});
    desc_full = {prod[2*METRIC_BITS+1], prod} -
                {{(METRIC_BITS+3){font_ascent[METRIC_BITS-1]}}, font_ascent};
    if (desc_full > $signed({{(2*METRIC_BITS+3-DESCENT_BITS){1'b0}},
                             1'b0, {(DESCENT_BITS-1){1'b1}}})) begin
      desc_sat = {1'b0, {(DESCENT_BITS-1){1'b1}}};
    end else if (desc_full < $signed({{(2*METRIC_BITS+3-DESCENT_BITS){1'b1}},
                                      1'b1, {(DESCENT_BITS-1){1'b0}}})) begin
      desc_sat = {1'b1, {(DESCENT_BITS-1){1'b0}}};
    end else begin
      desc_sat = desc_full[DESCENT_BITS-1:0];
    end
    width_out = (line_width_next > widest_width) ? line_width_next : widest_width;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width   <= '0;
      widest_width <= '0;
      line_count   <= COUNT_BITS'(1);
      esc_pending  <= 1'b0;
      skip_left    <= '0;
    end else if (s1_fire) begin
      if (s1_last) begin
        line_width   <= '0;
        widest_width <= '0;
        line_count   <= COUNT_BITS'(1);
        esc_pending  <= 1'b0;
        skip_left    <= '0;
      end else begin
        line_width   <= line_width_next;
        widest_width <= widest_width_next;
        line_count   <= line_count_next;
        esc_pending  <= esc_pending_next;
        skip_left    <= skip_left_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_fire && s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last) begin
      out_data.text_width   <= width_out;
      out_data.text_ascent  <= font_ascent;
      out_data.text_descent <= desc_sat;
    end
  end

  a_skip_no_escape: assert property (@(posedge clk) disable iff (rst)
    skip_left != '0 |-> !esc_pending)
    else $error("escape pending while skipping");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    line_count != '0)
    else $error("line count reached zero");

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !rst && !s1_fire |=> $stable(line_width) && $stable(line_count) &&
                         $stable(skip_left))
    else $error("string state changed with no character");

  a_last_result: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_last |=> out_valid && line_count == COUNT_BITS'(1) &&
                           line_width == '0 && skip_left == '0)
    else $error("last character did not close the string");

endmodule

[bench/text_line_metrics_test.sv]
`timescale 1ns / 100ps

// Self-checking bench for text_line_metrics: predicts each metrics word from the
// glyph table and register copies held here, and checks words as they leave.
// Depends on tlm_pkg and the text_line_metrics RTL.
module text_line_metrics_test;
  import tlm_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int DRAIN_CYCLES = 4;
  localparam int REPORT_CAP   = 60;
  localparam int MAX_GAP      = 40;
  localparam int WIDTH_MAX    = (1 << (WIDTH_BITS - 1)) - 1;
  localparam int WIDTH_MIN    = -(1 << (WIDTH_BITS - 1));
  localparam int COUNT_MAX    = (1 << COUNT_BITS) - 1;
  localparam longint DESCENT_MAX = (64'sd1 <<< (DESCENT_BITS - 1)) - 1;
  localparam longint DESCENT_MIN = -(64'sd1 <<< (DESCENT_BITS - 1));

  class text_metrics_board;
    bit [ENTRY_BITS-1:0] glyph_entry [TABLE_DEPTH];
    int first_code, code_span, font_ascent, font_descent;
    int line_width, widest_width, line_count, skip_left;
    bit esc_pending;
    out_word_t pending_metrics [$];
    int errors, reports, results_seen;

    function new();
      foreach (glyph_entry[i]) glyph_entry[i] = '0;
      first_code = 0;
      code_span = 256;
      font_ascent = 0;
      font_descent = 0;
      errors = 0;
      reports = 0;
      results_seen = 0;
      clear_line_state();
    endfunction

    function void clear_line_state();
      line_width = 0;
      widest_width = 0;
      line_count = 1;
      esc_pending = 1'b0;
      skip_left = 0;
    endfunction

    function void write_reg(cfg_index_t idx, logic [METRIC_BITS-1:0] val);
      shortint s;
      s = val;
      case (idx)
        CFG_FIRST_CODE:   first_code = int'(val[CODE_BITS-1:0]);
        CFG_CODE_SPAN:    code_span = int'(val[SPAN_BITS-1:0]);
        CFG_FONT_ASCENT:  font_ascent = s;
        CFG_FONT_DESCENT: font_descent = s;
        default: ;
      endcase
    endfunction

    function bit covered(int c);
      return c >= first_code && c < first_code + code_span;
    endfunction

    function bit read_glyph(int c, output int adv);
      int slot;
      byte a;
      adv = 0;
      slot = c - first_code;
      if (slot < 0 || slot >= TABLE_DEPTH) return 1'b0;
      if (!glyph_entry[slot][ADV_BITS]) return 1'b0;
      a = glyph_entry[slot][ADV_BITS-1:0];
      adv = a;
      return 1'b1;
    endfunction

    function bit glyph_advance(int c, output int adv);
      int other;
      adv = 0;
      if (!covered(c)) return 1'b0;
      if (read_glyph(c, adv)) return 1'b1;
      // missing letter: try the other case once
      if (c >= int'(LOWER_A) && c <= int'(LOWER_Z)) other = c - int'(CASE_BIT);
      else if (c >= int'(UPPER_A) && c <= int'(UPPER_Z)) other = c + int'(CASE_BIT);
      else return 1'b0;
      if (!covered(other)) return 1'b0;
      return read_glyph(other, adv);
    endfunction

    function void measure_char(int c, bit is_last);
      int adv, total;
      if (skip_left != 0) begin
        skip_left--;
        return;
      end
      if (esc_pending) begin
        esc_pending = 1'b0;
        if (c == int'(CHAR_M)) begin
          skip_left = int'(SKIP_M);
          return;
        end
        if (c == int'(CHAR_T) || c == int'(CHAR_L)) begin
          skip_left = int'(SKIP_TL);
          return;
        end
        if (c == int'(CHAR_F)) begin
          skip_left = int'(SKIP_F);
          return;
        end
      end
      if (c == int'(ESC_CODE)) begin
        esc_pending = 1'b1;
      end else if (c == int'(LF_CODE)) begin
        // a newline as the final character closes nothing
        if (!is_last) begin
          if (line_width > widest_width) widest_width = line_width;
          line_width = 0;
          if (line_count < COUNT_MAX) line_count++;
        end
      end else if (c != int'(CR_CODE) && glyph_advance(c, adv)) begin
        total = line_width + adv;
        if (total > WIDTH_MAX) total = WIDTH_MAX;
        if (total < WIDTH_MIN) total = WIDTH_MIN;
        line_width = total;
      end
    endfunction

    function void note_word(in_word_t w);
      out_word_t e;
      int widest;
      longint d;
      if (w.action == action_load) begin
        glyph_entry[w.code] = {w.entry_present, w.entry_advance};
        return;
      end
      measure_char(int'(w.code), w.last_char);
      if (!w.last_char) return;
      widest = (line_width > widest_width) ? line_width : widest_width;
      d = longint'(line_count) * (longint'(font_ascent) + longint'(font_descent))
          - longint'(font_ascent);
      if (d > DESCENT_MAX) d = DESCENT_MAX;
      if (d < DESCENT_MIN) d = DESCENT_MIN;
      e.text_width = widest[WIDTH_BITS-1:0];
      e.text_ascent = font_ascent[METRIC_BITS-1:0];
      e.text_descent = d[DESCENT_BITS-1:0];
      pending_metrics.push_back(e);
      clear_line_state();
    endfunction

    function void mismatch(string field, longint want, longint got);
      errors++;
      if (reports < REPORT_CAP)
        $display("%0t: %s expected %0d got %0d", $time, field, want, got);
      reports++;
    endfunction

    function void check_word(out_word_t got);
      out_word_t e;
      results_seen++;
      if (pending_metrics.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none got width %0d ascent %0d descent %0d",
                 $time, got.text_width, got.text_ascent, got.text_descent);
        return;
      end
      e = pending_metrics.pop_front();
      if (got.text_width !== e.text_width)
        mismatch("text_width", e.text_width, got.text_width);
      if (got.text_ascent !== e.text_ascent)
        mismatch("text_ascent", e.text_ascent, got.text_ascent);
      if (got.text_descent !== e.text_descent)
        mismatch("text_descent", e.text_descent, got.text_descent);
    endfunction

    function int pending();
      return pending_metrics.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_index_t cfg_index = CFG_FIRST_CODE;
  logic [METRIC_BITS-1:0] cfg_data = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycles = 0;
  int words_sent = 0;
  int settings_used = 0;
  text_metrics_board board = new();

  text_line_metrics DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (!rst) begin
      if (cfg_valid && cfg_ready) board.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) board.note_word(in_data);
      if (out_valid && out_ready) board.check_word(out_data);
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycles, board.pending());
      $display("status: fail");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_word(in_word_t w);
    int gap;
    gap = 0;
    while (send_idle_pct > 0 && gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    @(negedge clk);
  endtask

  // hold cfg_valid high across the four writes, drop it after the last
  task automatic put_reg(cfg_index_t idx, int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[METRIC_BITS-1:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic write_config(int first, int span, int asc, int desc);
    put_reg(CFG_FIRST_CODE, first);
    put_reg(CFG_CODE_SPAN, span);
    put_reg(CFG_FONT_ASCENT, asc);
    put_reg(CFG_FONT_DESCENT, desc);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // wait for every expected word, then let non-final characters leave the pipe
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic in_word_t char_word(int c, bit is_last);
    in_word_t w;
    w.action = action_measure;
    w.code = c[CODE_BITS-1:0];
    w.entry_present = 1'($urandom_range(1));
    w.entry_advance = ADV_BITS'($urandom);
    w.last_char = is_last;
    return w;
  endfunction

  function automatic in_word_t load_word(int slot, bit present, int adv);
    in_word_t w;
    w.action = action_load;
    w.code = slot[CODE_BITS-1:0];
    w.entry_present = present;
    w.entry_advance = adv[ADV_BITS-1:0];
    w.last_char = 1'($urandom_range(1));
    return w;
  endfunction

  function automatic int pick_char(bit after_esc);
    int r, c, n;
    r = $urandom_range(99);
    if (after_esc && r < 80) begin
      case ($urandom_range(3))
        0: return int'(CHAR_M);
        1: return int'(CHAR_T);
        2: return int'(CHAR_L);
        default: return int'(CHAR_F);
      endcase
    end
    if (r < 12) return int'(LF_CODE);
    if (r < 16) return int'(CR_CODE);
    if (r < 22) return int'(ESC_CODE);
    if (r < 32) begin
      n = $urandom_range(25);
      return $urandom_range(1) ? int'(LOWER_A) + n : int'(UPPER_A) + n;
    end
    if (r < 42 || board.code_span == 0) return $urandom_range(255);
    c = board.first_code + $urandom_range(board.code_span - 1);
    return (c > 255) ? $urandom_range(255) : c;
  endfunction

  task automatic random_string();
    int len, c;
    bit after_esc;
    len = $urandom_range(1, 16);
    after_esc = 1'b0;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 6)
        send_word(load_word($urandom_range(255), $urandom_range(3) != 0, $urandom));
      c = pick_char(after_esc);
      after_esc = (c == int'(ESC_CODE));
      send_word(char_word(c, i == len - 1));
    end
  endtask

  task automatic run_phase(int words);
    int stop, span;
    stop = words_sent + words;
    span = (board.code_span > TABLE_DEPTH) ? TABLE_DEPTH : board.code_span;
    // fill slots that the covered codes will actually read
    repeat (24) begin
      send_word(load_word(span == 0 ? $urandom_range(255) : $urandom_range(span - 1),
                          $urandom_range(4) != 0, $urandom));
    end
    while (words_sent < stop) random_string();
  endtask

  task automatic directed();
    in_word_t w;
    send_word(load_word(int'(UPPER_A), 1'b1, 127));
    send_word(load_word(int'(LOWER_A) + 1, 1'b1, -128));
    w = load_word(255, 1'b1, 5);
    w.last_char = 1'b1;
    send_word(w);
    send_word(load_word(0, 1'b0, -1));
    // case fallback both ways, CR, top code, newline, ESC M skip, broken escape
    send_word(char_word(int'(LOWER_A), 1'b0));
    send_word(char_word(int'(UPPER_A) + 1, 1'b0));
    send_word(char_word(int'(CR_CODE), 1'b0));
    send_word(char_word(255, 1'b0));
    send_word(char_word(int'(LF_CODE), 1'b0));
    send_word(char_word(int'(ESC_CODE), 1'b0));
    send_word(char_word(int'(CHAR_M), 1'b0));
    send_word(char_word(int'(ESC_CODE), 1'b0));
    send_word(char_word(int'(LOWER_A) + 23, 1'b0));
    send_word(char_word(int'(LOWER_A) + 24, 1'b0));
    send_word(char_word(int'(ESC_CODE), 1'b0));
    send_word(char_word(int'(UPPER_Z), 1'b0));
    send_word(char_word(int'(LF_CODE), 1'b1));
    // string ending inside a skip
    send_word(char_word(int'(ESC_CODE), 1'b0));
    send_word(char_word(int'(CHAR_F), 1'b0));
    send_word(char_word(int'(LOWER_A) + 16, 1'b0));
    send_word(char_word(int'(LOWER_A) + 17, 1'b1));
    send_word(char_word(int'(LF_CODE), 1'b1));
    send_word(char_word(0, 1'b1));
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    directed();
    settle();
    for (int p = 0; p < 8; p++) begin
      case (p / 2)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 74;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 74;
        end
        default: begin
          send_idle_pct = 15;
          recv_stall_pct = 15;
        end
      endcase
      case (p)
        0: write_config(0, 256, 32767, -32768);
        1: write_config(255, 1, -32768, 32767);
        2: write_config(int'(LOWER_A), 26, 12, 4);
        3: write_config(int'(UPPER_A), 58, $urandom_range(65535), $urandom_range(65535));
        4: write_config(0, 0, -32768, -32768);
        5: write_config(200, 511, 32767, 32767);
        6: write_config($urandom_range(255), $urandom_range(1, 256), $urandom, $urandom);
        default: write_config(32, 96, 20, 6);
      endcase
      run_phase(200);
      settle();
    end
    $display("checked %0d metric words produced by %0d input words", board.results_seen,
             words_sent);
    $display("%0d register settings incl. span and metric extremes, four idle/stall mixes",
             settings_used);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d words still expected", board.errors, board.pending());
      $display("status: fail");
    end
    $finish;
  end

endmodule
